@@ hdl/dagpb_pkg.sv @@
package dagpb_pkg;

   localparam int MAX_HASH_BYTES = 64;
   localparam int MAX_NAME_BYTES = 255;
   localparam int MAX_DATA_BYTES = 1048576;

   localparam int MODE_W   = 2;
   localparam int CID_W    = 7;
   localparam int NAME_W   = 8;
   localparam int SIZE_W   = 64;
   localparam int DLEN_W   = 21;
   localparam int BYTE_W   = 8;
   localparam int BLEFT_W  = 21;
   localparam int BODY_W   = 9;
   localparam int VLEN_W   = 4;

   localparam logic [MODE_W-1:0] MODE_LINK    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PAYLOAD = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DATA    = 2'd2;

   localparam logic [BYTE_W-1:0] TAG_LINK = 8'h12;
   localparam logic [BYTE_W-1:0] TAG_HASH = 8'h0A;
   localparam logic [BYTE_W-1:0] TAG_NAME = 8'h12;
   localparam logic [BYTE_W-1:0] TAG_SIZE = 8'h18;
   localparam logic [BYTE_W-1:0] TAG_DATA = 8'h0A;

   localparam logic [BYTE_W-1:0] VARINT_MORE = 8'h80;
   localparam logic [BYTE_W-1:0] VARINT_MASK = 8'h7F;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HASH,
      PH_NAME,
      PH_DATA
   } phase_type;

   typedef enum logic [3:0] {
      SQ_IDLE,
      SQ_LINK_TAG,
      SQ_BODY,
      SQ_HASH_TAG,
      SQ_CID,
      SQ_NAME_TAG,
      SQ_NAME_LEN,
      SQ_SIZE_TAG,
      SQ_SIZE,
      SQ_DATA_TAG,
      SQ_DATA_LEN,
      SQ_PASS,
      SQ_ERR
   } seq_state_type;

   typedef enum logic [2:0] {
      IK_LINK,
      IK_PAY,
      IK_DATA,
      IK_EMPTY,
      IK_ERR
   } item_kind_type;

   typedef struct packed {
      logic load;
      logic shift;
   } vu_ctrl_type;

   // Number of bytes in the varint encoding of a 64-bit value.
   function automatic logic [VLEN_W-1:0] varint_len(input logic [SIZE_W-1:0] v);
      logic [VLEN_W-1:0] len;
      len = VLEN_W'(1);
      for (int i = 1; i < 10; i++) begin
         if ((v >> (7 * i)) != '0) begin
            len = VLEN_W'(i + 1);
         end
      end
      return len;
   endfunction

endpackage

@@ hdl/dagpb_if.sv @@
interface dagpb_req_if;
   import dagpb_pkg::*;
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [CID_W-1:0]    cid_length;
   logic [NAME_W-1:0]   name_length;
   logic [SIZE_W-1:0]   link_size;
   logic [DLEN_W-1:0]   data_length;
   logic [BYTE_W-1:0]   payload_byte;

   modport source(output valid, mode, cid_length, name_length, link_size, data_length,
                  payload_byte, input ready);
   modport sink(input valid, mode, cid_length, name_length, link_size, data_length,
                payload_byte, output ready);
endinterface

interface dagpb_rsp_if;
   import dagpb_pkg::*;
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   out_byte;
   logic                last_of_item;
   logic                sequence_error;

   modport source(output valid, out_byte, last_of_item, sequence_error, input ready);
   modport sink(input valid, out_byte, last_of_item, sequence_error, output ready);
endinterface

interface dagpb_csr_if;
   logic valid;
   logic ready;
   logic data;

   modport source(output valid, data, input ready);
   modport sink(input valid, data, output ready);
endinterface

@@ hdl/dagpb_varint_unit.sv @@
module dagpb_varint_unit (
   input  logic                          clock,
   input  dagpb_pkg::vu_ctrl_type        ctrl,
   input  logic [dagpb_pkg::SIZE_W-1:0]  load_value,
   output logic [dagpb_pkg::BYTE_W-1:0]  vu_byte,
   output logic                          vu_last
);
   import dagpb_pkg::*;

   logic [SIZE_W-1:0] val_ff;
   logic [SIZE_W-1:0] val_in;

   // Each shift strips the seven bits just sent; the value is done once
   // nothing remains above the low group.
   assign vu_last = (val_ff[SIZE_W-1:7] == '0);
   assign vu_byte = (val_ff[BYTE_W-1:0] & VARINT_MASK) | (vu_last ? '0 : VARINT_MORE);

   always_comb begin
      val_in = val_ff;
      if (ctrl.load) begin
         val_in = load_value;
      end else if (ctrl.shift) begin
         val_in = val_ff >> 7;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

@@ hdl/dagpb_link_field_serializer.sv @@
// Serializes dag-pb link and data fields into protobuf bytes, one byte per
// sequencer step through a registered output stage; a step waits while the
// output is stalled. A payload transaction is accepted and its byte then moves
// into the output stage. A payload transaction that closes a hash or name
// field also emits the tag and varint bytes that follow it, up to the next
// payload field or the end of the link. A header transaction emits its bytes
// in turn: tag bytes go out directly, and varints go out through a single
// shared shift unit, stepped by the sequencer, that sheds seven bits per step.
// A data header with zero length emits no byte, and a rejected transaction
// emits one error byte. The request channel is not ready while the sequencer
// is busy.
module dagpb_link_field_serializer (
   input  logic        clock,
   input  logic        reset,
   dagpb_req_if.sink   req_ch,
   dagpb_rsp_if.source rsp_ch,
   dagpb_csr_if.sink   csr_ch
);
   import dagpb_pkg::*;

   seq_state_type      sq_ff, sq_in;
   phase_type          phase_ff, phase_in;
   logic [BLEFT_W-1:0] bytes_left_ff, bytes_left_in;
   logic [NAME_W-1:0]  name_len_ff, name_len_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [BODY_W-1:0]  body_ff, body_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic               aen_ff;

   logic               rsp_valid_ff;
   logic [BYTE_W-1:0]  rsp_byte_ff;
   logic               rsp_last_ff;
   logic               rsp_err_ff;

   item_kind_type      kind;
   logic               acc;
   logic               adv;
   logic               out_fire;
   logic [BYTE_W-1:0]  emit_byte;
   logic               emit_last;
   logic               emit_err;
   vu_ctrl_type        vu_ctrl;
   logic [SIZE_W-1:0]  vu_load_value;
   logic [BYTE_W-1:0]  vu_byte;
   logic               vu_last;
   logic               name_on;
   logic               hdr_name_on;
   logic [BODY_W-1:0]  body_calc;

   assign acc      = req_ch.valid && req_ch.ready;
   assign adv      = !rsp_valid_ff || rsp_ch.ready;
   assign out_fire = (sq_ff != SQ_IDLE) && adv;
   assign name_on  = aen_ff || (name_len_ff != '0);

   assign req_ch.ready = (sq_ff == SQ_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.out_byte       = rsp_byte_ff;
   assign rsp_ch.last_of_item   = rsp_last_ff;
   assign rsp_ch.sequence_error = rsp_err_ff;

   dagpb_varint_unit u_varint (
      .clock      (clock),
      .ctrl       (vu_ctrl),
      .load_value (vu_load_value),
      .vu_byte    (vu_byte),
      .vu_last    (vu_last)
   );

   // Length of the link body: hash field, optional name field, size field.
   assign hdr_name_on = aen_ff || (req_ch.name_length != '0);
   always_comb begin
      body_calc = BODY_W'(3) + BODY_W'(req_ch.cid_length)
                + BODY_W'(varint_len(req_ch.link_size));
      if (hdr_name_on) begin
         body_calc = body_calc + BODY_W'(1) + BODY_W'(req_ch.name_length)
                   + ((req_ch.name_length >= 8'h80) ? BODY_W'(2) : BODY_W'(1));
      end
   end

   always_comb begin
      kind = IK_ERR;
      unique case (req_ch.mode)
         MODE_LINK: begin
            if (phase_ff == PH_IDLE && int'(req_ch.cid_length) <= MAX_HASH_BYTES
                && int'(req_ch.name_length) <= MAX_NAME_BYTES) begin
               kind = IK_LINK;
            end
         end
         MODE_PAYLOAD: begin
            if (phase_ff != PH_IDLE && bytes_left_ff != '0) begin
               kind = IK_PAY;
            end
         end
         MODE_DATA: begin
            if (phase_ff == PH_IDLE && int'(req_ch.data_length) <= MAX_DATA_BYTES) begin
               kind = (req_ch.data_length == '0) ? IK_EMPTY : IK_DATA;
            end
         end
         default: kind = IK_ERR;
      endcase
   end

   // Sequencer next state.
   always_comb begin
      sq_in = sq_ff;
      if (sq_ff == SQ_IDLE) begin
         if (acc) begin
            unique case (kind)
               IK_LINK:  sq_in = SQ_LINK_TAG;
               IK_PAY:   sq_in = SQ_PASS;
               IK_DATA:  sq_in = SQ_DATA_TAG;
               IK_EMPTY: sq_in = SQ_IDLE;
               default:  sq_in = SQ_ERR;
            endcase
         end
      end else if (adv) begin
         unique case (sq_ff)
            SQ_LINK_TAG: sq_in = SQ_BODY;
            SQ_BODY:     sq_in = vu_last ? SQ_HASH_TAG : SQ_BODY;
            SQ_HASH_TAG: sq_in = SQ_CID;
            SQ_CID: begin
               if (vu_last) begin
                  if (bytes_left_ff != '0) begin
                     sq_in = SQ_IDLE;
                  end else begin
                     sq_in = name_on ? SQ_NAME_TAG : SQ_SIZE_TAG;
                  end
               end
            end
            SQ_NAME_TAG: sq_in = SQ_NAME_LEN;
            SQ_NAME_LEN: begin
               if (vu_last) begin
                  sq_in = (name_len_ff != '0) ? SQ_IDLE : SQ_SIZE_TAG;
               end
            end
            SQ_SIZE_TAG: sq_in = SQ_SIZE;
            SQ_SIZE:     sq_in = vu_last ? SQ_IDLE : SQ_SIZE;
            SQ_DATA_TAG: sq_in = SQ_DATA_LEN;
            SQ_DATA_LEN: sq_in = vu_last ? SQ_IDLE : SQ_DATA_LEN;
            SQ_PASS: begin
               sq_in = SQ_IDLE;
               if (bytes_left_ff == '0) begin
                  if (phase_ff == PH_HASH) begin
                     sq_in = name_on ? SQ_NAME_TAG : SQ_SIZE_TAG;
                  end else if (phase_ff == PH_NAME) begin
                     sq_in = SQ_SIZE_TAG;
                  end
               end
            end
            default:     sq_in = SQ_IDLE;
         endcase
      end
   end

   // Sequencer outputs: the byte for this step and the shift unit controls.
   always_comb begin
      emit_byte     = '0;
      emit_last     = 1'b0;
      emit_err      = 1'b0;
      vu_ctrl       = '0;
      vu_load_value = '0;
      unique case (sq_ff)
         SQ_IDLE: begin
            emit_byte = '0;
         end
         SQ_LINK_TAG: begin
            emit_byte     = TAG_LINK;
            vu_ctrl.load  = adv;
            vu_load_value = SIZE_W'(body_ff);
         end
         SQ_HASH_TAG: begin
            emit_byte     = TAG_HASH;
            vu_ctrl.load  = adv;
            vu_load_value = SIZE_W'(bytes_left_ff);
         end
         SQ_NAME_TAG: begin
            emit_byte     = TAG_NAME;
            vu_ctrl.load  = adv;
            vu_load_value = SIZE_W'(name_len_ff);
         end
         SQ_SIZE_TAG: begin
            emit_byte     = TAG_SIZE;
            vu_ctrl.load  = adv;
            vu_load_value = size_ff;
         end
         SQ_DATA_TAG: begin
            emit_byte     = TAG_DATA;
            vu_ctrl.load  = adv;
            vu_load_value = SIZE_W'(bytes_left_ff);
         end
         SQ_BODY: begin
            emit_byte     = vu_byte;
            vu_ctrl.shift = adv;
         end
         SQ_CID: begin
            emit_byte     = vu_byte;
            vu_ctrl.shift = adv;
            emit_last     = vu_last && (bytes_left_ff != '0);
         end
         SQ_NAME_LEN: begin
            emit_byte     = vu_byte;
            vu_ctrl.shift = adv;
            emit_last     = vu_last && (name_len_ff != '0);
         end
         SQ_SIZE, SQ_DATA_LEN: begin
            emit_byte     = vu_byte;
            vu_ctrl.shift = adv;
            emit_last     = vu_last;
         end
         SQ_PASS: begin
            emit_byte = byte_ff;
            emit_last = !((bytes_left_ff == '0)
                          && (phase_ff == PH_HASH || phase_ff == PH_NAME));
         end
         SQ_ERR: begin
            emit_byte = '0;
            emit_last = 1'b1;
            emit_err  = 1'b1;
         end
         default: begin
            emit_byte = '0;
         end
      endcase
   end

   // Link and field state. The phase changes when the sequencer sends the last
   // byte of a hash or name header, of a link, or of a data field; a data header enters the data phase when accepted.
   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      name_len_in   = name_len_ff;
      size_in       = size_ff;
      body_in       = body_ff;
      byte_in       = byte_ff;
      if (acc) begin
         case (kind)
            IK_LINK: begin
               name_len_in   = req_ch.name_length;
               size_in       = req_ch.link_size;
               bytes_left_in = BLEFT_W'(req_ch.cid_length);
               body_in       = body_calc;
            end
            IK_PAY: begin
               bytes_left_in = bytes_left_ff - BLEFT_W'(1);
               byte_in       = req_ch.payload_byte;
            end
            IK_DATA: begin
               phase_in      = PH_DATA;
               bytes_left_in = BLEFT_W'(req_ch.data_length);
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end else if (adv) begin
         case (sq_ff)
            SQ_CID: begin
               if (vu_last && bytes_left_ff != '0) begin
                  phase_in = PH_HASH;
               end
            end
            SQ_NAME_LEN: begin
               if (vu_last && name_len_ff != '0) begin
                  phase_in      = PH_NAME;
                  bytes_left_in = BLEFT_W'(name_len_ff);
               end
            end
            SQ_SIZE: begin
               if (vu_last) begin
                  phase_in      = PH_IDLE;
                  bytes_left_in = '0;
               end
            end
            SQ_PASS: begin
               if (bytes_left_ff == '0 && phase_ff == PH_DATA) begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff         <= SQ_IDLE;
         phase_ff      <= PH_IDLE;
         bytes_left_ff <= '0;
         aen_ff        <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         sq_ff         <= sq_in;
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         if (csr_ch.valid && csr_ch.ready) begin
            aen_ff <= csr_ch.data;
         end
         if (out_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      name_len_ff <= name_len_in;
      size_ff     <= size_in;
      body_ff     <= body_in;
      byte_ff     <= byte_in;
      if (out_fire) begin
         rsp_byte_ff <= emit_byte;
         rsp_last_ff <= emit_last;
         rsp_err_ff  <= emit_err;
      end
   end

   // An error transaction is always a single zero byte that closes the item.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_last_ff && rsp_byte_ff == '0))
      else $error("error transaction is not a closing zero byte");

   // Between items, an open field always has bytes still to come.
   assert property (@(posedge clock) disable iff (reset)
      (sq_ff == SQ_IDLE && phase_ff != PH_IDLE) |-> (bytes_left_ff != '0))
      else $error("open field with no bytes left");

   // The hash length fits in one varint byte, so the shift unit must be done.
   assert property (@(posedge clock) disable iff (reset)
      (sq_ff == SQ_CID) |-> vu_last)
      else $error("hash length varint longer than one byte");

   // Each step of the sequencer moves exactly one byte into the output stage.
   assert property (@(posedge clock) disable iff (reset)
      out_fire |=> rsp_valid_ff)
      else $error("sequencer step lost its byte");

endmodule
